/* sv/multi_channel_periodic_tick_timer_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the periodic tick timer
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_PERIODIC_TICK_TIMER_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_PERIODIC_TICK_TIMER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCTT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mctt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_pkg
// Shared widths, command codes, control word layout and the microcode table
// of the periodic tick timer.
// ----------------------------------------------------------------------------
package mctt_pkg;

	localparam int CMD_W        = 3;
	localparam int CH_W         = 3;
	localparam int VAL_W        = 64;
	localparam int MASK_W       = 8;
	localparam int CHANNELS_DEF = 8;
	localparam int STEP_W       = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK      = 3'd0,
		CMD_ADD       = 3'd1,
		CMD_SET_EN    = 3'd2,
		CMD_SET_COUNT = 3'd3,
		CMD_GET_COUNT = 3'd4
	} cmd_t;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_FETCH    = 4'd0;
	localparam step_t STEP_DISPATCH = 4'd1;
	localparam step_t STEP_T_RD     = 4'd2;
	localparam step_t STEP_T_INC    = 4'd3;
	localparam step_t STEP_T_WR     = 4'd4;
	localparam step_t STEP_ADD      = 4'd5;
	localparam step_t STEP_SET_EN   = 4'd6;
	localparam step_t STEP_SET_CNT  = 4'd7;
	localparam step_t STEP_GET_RD   = 4'd8;
	localparam step_t STEP_GET_RES  = 4'd9;
	localparam step_t STEP_RESP     = 4'd10;

	typedef enum logic [2:0] {
		SEQ_WAIT_CMD,
		SEQ_DISPATCH,
		SEQ_NEXT,
		SEQ_JUMP,
		SEQ_BR_DONE,
		SEQ_WAIT_OUT
	} seq_op_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LATCH,
		DP_TICK_RD,
		DP_TICK_INC,
		DP_TICK_WR,
		DP_ADD,
		DP_SET_EN,
		DP_SET_CNT,
		DP_GET_RD,
		DP_GET_RES,
		DP_RESP
	} dp_op_t;

	typedef struct packed {
		logic    ready;
		seq_op_t seq;
		step_t   target;
		dp_op_t  dp;
	} ctrl_t;

	typedef struct packed {
		logic             cmd_valid;
		logic [CMD_W-1:0] command;
		logic             loop_done;
		logic             out_free;
	} seq_cond_t;

	function automatic ctrl_t ucode_rom(input step_t pc);
		ctrl_t cw;
		cw = '{ready: 1'b0, seq: SEQ_JUMP, target: STEP_FETCH, dp: DP_NONE};
		unique case (pc)
			STEP_FETCH:    cw = '{1'b1, SEQ_WAIT_CMD, STEP_FETCH, DP_LATCH};
			STEP_DISPATCH: cw = '{1'b0, SEQ_DISPATCH, STEP_FETCH, DP_NONE};
			STEP_T_RD:     cw = '{1'b0, SEQ_BR_DONE,  STEP_RESP,  DP_TICK_RD};
			STEP_T_INC:    cw = '{1'b0, SEQ_NEXT,     STEP_FETCH, DP_TICK_INC};
			STEP_T_WR:     cw = '{1'b0, SEQ_JUMP,     STEP_T_RD,  DP_TICK_WR};
			STEP_ADD:      cw = '{1'b0, SEQ_JUMP,     STEP_RESP,  DP_ADD};
			STEP_SET_EN:   cw = '{1'b0, SEQ_JUMP,     STEP_RESP,  DP_SET_EN};
			STEP_SET_CNT:  cw = '{1'b0, SEQ_JUMP,     STEP_RESP,  DP_SET_CNT};
			STEP_GET_RD:   cw = '{1'b0, SEQ_NEXT,     STEP_FETCH, DP_GET_RD};
			STEP_GET_RES:  cw = '{1'b0, SEQ_NEXT,     STEP_FETCH, DP_GET_RES};
			STEP_RESP:     cw = '{1'b0, SEQ_WAIT_OUT, STEP_FETCH, DP_RESP};
			default:       cw = '{1'b0, SEQ_JUMP,     STEP_FETCH, DP_NONE};
		endcase
		return cw;
	endfunction

	function automatic step_t dispatch_target(input logic [CMD_W-1:0] command);
		step_t tgt;
		tgt = STEP_RESP;
		unique case (command)
			CMD_TICK:      tgt = STEP_T_RD;
			CMD_ADD:       tgt = STEP_ADD;
			CMD_SET_EN:    tgt = STEP_SET_EN;
			CMD_SET_COUNT: tgt = STEP_SET_CNT;
			CMD_GET_COUNT: tgt = STEP_GET_RD;
			default:       tgt = STEP_RESP;
		endcase
		return tgt;
	endfunction

endpackage

/* sv/mctt_cmd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_cmd_if
// Command channel of the tick timer: valid/ready handshake with the command
// fields as payload.
// ----------------------------------------------------------------------------
interface mctt_cmd_if
	import mctt_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [CH_W-1:0]  channel;
	logic [VAL_W-1:0] value;
	logic             enable_value;
	logic             has_handler;

	modport source (
		output valid, command, channel, value, enable_value, has_handler,
		input  ready
	);

	modport sink (
		input  valid, command, channel, value, enable_value, has_handler,
		output ready
	);
endinterface

/* sv/mctt_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_rsp_if
// Response channel of the tick timer: valid/ready handshake with the result
// fields as payload.
// ----------------------------------------------------------------------------
interface mctt_rsp_if
	import mctt_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              status;
	logic [CH_W-1:0]   new_channel;
	logic [VAL_W-1:0]  count_read;
	logic [MASK_W-1:0] fire_mask;

	modport source (
		output valid, status, new_channel, count_read, fire_mask,
		input  ready
	);

	modport sink (
		input  valid, status, new_channel, count_read, fire_mask,
		output ready
	);
endinterface

/* sv/mctt_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_seq
// Microcode sequencer: step counter, control word table and branch logic.
// ----------------------------------------------------------------------------
module mctt_seq
	import mctt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  seq_cond_t cond,
	output ctrl_t     ctrl
);

	step_t pc_q;
	step_t pc_d;
	step_t pc_inc;

	assign ctrl   = ucode_rom(pc_q);
	assign pc_inc = pc_q + step_t'(1);

	always_comb begin
		pc_d = pc_q;
		unique case (ctrl.seq)
			SEQ_WAIT_CMD: pc_d = cond.cmd_valid ? pc_inc : pc_q;
			SEQ_DISPATCH: pc_d = dispatch_target(cond.command);
			SEQ_NEXT:     pc_d = pc_inc;
			SEQ_JUMP:     pc_d = ctrl.target;
			SEQ_BR_DONE:  pc_d = cond.loop_done ? ctrl.target : pc_inc;
			SEQ_WAIT_OUT: pc_d = cond.out_free ? ctrl.target : pc_q;
			default:      pc_d = STEP_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

/* sv/multi_channel_periodic_tick_timer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_periodic_tick_timer_unit
// Bank of periodic channels driven by tick, add, set enable, set count and
// get count commands, controlled by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Each command transaction yields exactly one response transaction. A command
// is taken only while the sequencer sits in its fetch step, so the block works
// on one command at a time; a finished response waits in an output register
// while the next command is already being taken. Add, set enable and set count
// pass through the fetch, dispatch, own and response steps, get count has a read
// step and a result step in place of its own step, and a tick walks the added
// channels one by one through a read, increment and compare-and-write step on
// the count store, which has a single write port. Counts and periods are not
// cleared at reset; add writes both before a channel can be addressed.
module multi_channel_periodic_tick_timer_unit
	import mctt_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mctt_cmd_if.sink   cmd,
	mctt_rsp_if.source rsp
);

	localparam int IU_W = $clog2(CHANNELS + 1);
	localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	ctrl_t     ctrl;
	seq_cond_t cond;

	// Latched command fields.
	logic [CMD_W-1:0] cmd_command_q;
	logic [CH_W-1:0]  cmd_channel_q;
	logic [VAL_W-1:0] cmd_value_q;
	logic             cmd_en_q;
	logic             cmd_hh_q;

	logic [IU_W-1:0]     in_use_q;
	logic [IU_W-1:0]     ptr_q;
	logic [CHANNELS-1:0] en_q;
	logic [CHANNELS-1:0] hh_q;

	logic [VAL_W-1:0] count_mem [CHANNELS];
	logic [VAL_W-1:0] period_mem [CHANNELS];
	logic [VAL_W-1:0] count_rd_q;
	logic [VAL_W-1:0] period_rd_q;
	logic [VAL_W-1:0] inc_q;

	logic                res_status_q;
	logic [CH_W-1:0]     res_newch_q;
	logic [VAL_W-1:0]    res_count_q;
	logic [CHANNELS-1:0] mask_q;

	logic              out_valid_q;
	logic              out_status_q;
	logic [CH_W-1:0]   out_newch_q;
	logic [VAL_W-1:0]  out_count_q;
	logic [MASK_W-1:0] out_mask_q;

	logic            accept;
	logic            out_free;
	logic            added;
	logic            can_add;
	logic            tick_fire;
	logic [AW-1:0]   ch_idx;
	logic [AW-1:0]   ptr_idx;
	logic [AW-1:0]   add_idx;
	logic [AW-1:0]   rd_addr;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [VAL_W-1:0] mem_wdata;
	logic [CH_W:0]   in_use_x;

	mctt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctrl   (ctrl)
	);

	assign cmd.ready = ctrl.ready;
	assign accept    = cmd.valid && ctrl.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign cond.cmd_valid = cmd.valid;
	assign cond.command   = cmd_command_q;
	assign cond.loop_done = (ptr_q >= in_use_q);
	assign cond.out_free  = out_free;

	assign in_use_x  = (CH_W + 1)'(in_use_q);
	assign added     = ({1'b0, cmd_channel_q} < in_use_x);
	assign can_add   = (in_use_q < IU_W'(CHANNELS));
	assign ch_idx    = cmd_channel_q[AW-1:0];
	assign ptr_idx   = ptr_q[AW-1:0];
	assign add_idx   = in_use_q[AW-1:0];
	assign rd_addr   = (ctrl.dp == DP_GET_RD) ? ch_idx : ptr_idx;
	assign tick_fire = hh_q[ptr_idx] && (period_rd_q != '0) && (inc_q >= period_rd_q);

	// One write port on the count store, shared by tick, add and set count.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_idx;
		mem_wdata = '0;
		unique case (ctrl.dp)
			DP_TICK_WR: begin
				mem_we    = en_q[ptr_idx];
				mem_waddr = ptr_idx;
				mem_wdata = tick_fire ? '0 : inc_q;
			end
			DP_ADD: begin
				mem_we    = can_add;
				mem_waddr = add_idx;
				mem_wdata = '0;
			end
			DP_SET_CNT: begin
				mem_we    = added && en_q[ch_idx];
				mem_waddr = ch_idx;
				mem_wdata = cmd_value_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			count_mem[mem_waddr] <= mem_wdata;
		end
		if (ctrl.dp == DP_ADD && can_add) begin
			period_mem[add_idx] <= cmd_value_q;
		end
		count_rd_q  <= count_mem[rd_addr];
		period_rd_q <= period_mem[rd_addr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q    <= '0;
			ptr_q       <= '0;
			en_q        <= '0;
			hh_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.dp == DP_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (ctrl.dp)
				DP_LATCH: begin
					if (accept) begin
						ptr_q <= '0;
					end
				end
				DP_TICK_WR: begin
					ptr_q <= ptr_q + IU_W'(1);
				end
				DP_ADD: begin
					if (can_add) begin
						en_q[add_idx] <= 1'b1;
						hh_q[add_idx] <= cmd_hh_q;
						in_use_q      <= in_use_q + IU_W'(1);
					end
				end
				DP_SET_EN: begin
					if (added) begin
						en_q[ch_idx] <= cmd_en_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (ctrl.dp)
			DP_LATCH: begin
				if (accept) begin
					cmd_command_q <= cmd.command;
					cmd_channel_q <= cmd.channel;
					cmd_value_q   <= cmd.value;
					cmd_en_q      <= cmd.enable_value;
					cmd_hh_q      <= cmd.has_handler;
					res_status_q  <= 1'b0;
					res_newch_q   <= '0;
					res_count_q   <= '0;
					mask_q        <= '0;
				end
			end
			DP_TICK_INC: begin
				inc_q <= (count_rd_q == '1) ? count_rd_q : count_rd_q + VAL_W'(1);
			end
			DP_TICK_WR: begin
				if (en_q[ptr_idx] && tick_fire) begin
					mask_q[ptr_idx] <= 1'b1;
				end
			end
			DP_ADD: begin
				if (can_add) begin
					res_newch_q <= CH_W'(in_use_q);
				end else begin
					res_status_q <= 1'b1;
				end
			end
			DP_SET_EN, DP_SET_CNT: begin
				if (!added) begin
					res_status_q <= 1'b1;
				end
			end
			DP_GET_RES: begin
				if (!added) begin
					res_status_q <= 1'b1;
				end else if (en_q[ch_idx]) begin
					res_count_q <= count_rd_q;
				end
			end
			DP_RESP: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_newch_q  <= res_newch_q;
					out_count_q  <= res_count_q;
					out_mask_q   <= MASK_W'(mask_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.new_channel = out_newch_q;
	assign rsp.count_read  = out_count_q;
	assign rsp.fire_mask   = out_mask_q;

endmodule

/* sv/mctt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_checker
// Port-level checks of the tick timer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "multi_channel_periodic_tick_timer_unit_assert.svh"

module mctt_checker
	import mctt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic              rsp_status,
	input logic [CH_W-1:0]   rsp_new_channel,
	input logic [VAL_W-1:0]  rsp_count_read,
	input logic [MASK_W-1:0] rsp_fire_mask
);

	// Commands accepted whose responses have not yet been delivered.
	logic [2:0] pending_q;
	logic       cmd_xfer;
	logic       rsp_xfer;

	assign cmd_xfer = cmd_valid && cmd_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(cmd_xfer) - 3'(rsp_xfer);
		end
	end

	`MCTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_new_channel) && $stable(rsp_count_read) && $stable(rsp_fire_mask), "response changed while stalled")
	`MCTT_ASSERT_SAME(a_err_clean, rsp_valid && rsp_status, rsp_new_channel == '0 && rsp_count_read == '0 && rsp_fire_mask == '0, "error response carries data")
	`MCTT_ASSERT_SAME(a_pending_max, 1'b1, pending_q <= 3'd2, "more than two transactions in flight")
	`MCTT_ASSERT_SAME(a_no_orphan, rsp_valid, pending_q != 3'd0, "response without a command")
	`MCTT_ASSERT_SAME(a_full_stall, pending_q == 3'd2, !cmd_ready, "command taken while full")

endmodule

bind multi_channel_periodic_tick_timer_unit mctt_checker u_mctt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_new_channel (rsp.new_channel),
	.rsp_count_read  (rsp.count_read),
	.rsp_fire_mask   (rsp.fire_mask)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the periodic tick timer against a cycle-free model of its channel
// bank: directed commands first, then random traffic with idling on both
// channels, a back-to-back stretch and a long stall on the response side.
// ----------------------------------------------------------------------------
module testbench;
	import mctt_pkg::*;

	localparam logic [VAL_W-1:0] COUNT_ALL_ONES = {VAL_W{1'b1}};
	localparam logic [VAL_W-1:0] TOP_BIT_ONLY   = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 3'd7;
	localparam int IDLE_PERCENT  = 21;
	localparam int STALL_CYCLES  = 400;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int REPORT_LIMIT  = 200;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [CH_W-1:0]  channel;
		logic [VAL_W-1:0] value;
		logic             enable_value;
		logic             has_handler;
	} timer_cmd_t;

	typedef struct packed {
		logic              status;
		logic [CH_W-1:0]   new_channel;
		logic [VAL_W-1:0]  count_read;
		logic [MASK_W-1:0] fire_mask;
	} timer_rsp_t;

	logic clk;
	logic arst_n;

	mctt_cmd_if cmd_bus ();
	mctt_rsp_if rsp_bus ();

	multi_channel_periodic_tick_timer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	// Model of the channel bank.
	int                chans_added;
	logic              chan_en      [CHANNELS_DEF];
	logic [VAL_W-1:0]  chan_count   [CHANNELS_DEF];
	logic [VAL_W-1:0]  chan_period  [CHANNELS_DEF];
	logic              chan_handler [CHANNELS_DEF];

	timer_rsp_t expected_rsps[$];

	int  errors;
	int  cmds_sent;
	int  ticks_sent;
	int  rsps_checked;
	int  fires_seen;
	int  cycle_count;
	bit  no_idle;
	bit  hold_off_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("%0t: timeout after %0d cycles, %0d responses outstanding",
					$time, cycle_count, expected_rsps.size());
				$display("multi_channel_periodic_tick_timer_unit: mismatch");
				$finish;
			end
		end
	end

	function automatic timer_rsp_t apply_command(input timer_cmd_t c);
		timer_rsp_t r;
		logic       added;
		r = '0;
		added = (int'(c.channel) < chans_added);
		case (c.command)
			CMD_TICK: begin
				for (int i = 0; i < CHANNELS_DEF; i++) begin
					if (i < chans_added && chan_en[i]) begin
						if (chan_count[i] != COUNT_ALL_ONES)
							chan_count[i] = chan_count[i] + VAL_W'(1);
						if (chan_period[i] != '0 && chan_handler[i] &&
								chan_count[i] >= chan_period[i]) begin
							chan_count[i] = '0;
							r.fire_mask[i] = 1'b1;
						end
					end
				end
			end
			CMD_ADD: begin
				if (chans_added < CHANNELS_DEF) begin
					chan_count[chans_added]   = '0;
					chan_period[chans_added]  = c.value;
					chan_handler[chans_added] = c.has_handler;
					chan_en[chans_added]      = 1'b1;
					r.new_channel = chans_added[CH_W-1:0];
					chans_added++;
				end else begin
					r.status = 1'b1;
				end
			end
			CMD_SET_EN: begin
				if (added)
					chan_en[c.channel] = c.enable_value;
				else
					r.status = 1'b1;
			end
			CMD_SET_COUNT: begin
				if (!added)
					r.status = 1'b1;
				else if (chan_en[c.channel])
					chan_count[c.channel] = c.value;
			end
			CMD_GET_COUNT: begin
				if (!added)
					r.status = 1'b1;
				else if (chan_en[c.channel])
					r.count_read = chan_count[c.channel];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic timer_cmd_t make_cmd(input logic [CMD_W-1:0] op,
			input logic [CH_W-1:0] ch, input logic [VAL_W-1:0] val,
			input logic en, input logic hh);
		timer_cmd_t c;
		c.command      = op;
		c.channel      = ch;
		c.value        = val;
		c.enable_value = en;
		c.has_handler  = hh;
		return c;
	endfunction

	// Mostly ticks, counts near the periods and reads, with a sprinkling of
	// failing adds and reserved codes.
	function automatic timer_cmd_t random_command();
		timer_cmd_t c;
		int         pick;
		int         kind;
		c = make_cmd(CMD_TICK, CH_W'($urandom_range(0, CHANNELS_DEF - 1)),
			{$urandom, $urandom}, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		pick = $urandom_range(0, 99);
		if (pick < 38) begin
			c.command = CMD_TICK;
		end else if (pick < 55) begin
			c.command = CMD_SET_COUNT;
			kind = $urandom_range(0, 9);
			if (kind < 4)
				c.value = VAL_W'($urandom_range(0, 12));
			else if (kind < 6)
				c.value = COUNT_ALL_ONES - VAL_W'($urandom_range(0, 2));
			else if (kind < 7)
				c.value = TOP_BIT_ONLY - VAL_W'($urandom_range(0, 2));
		end else if (pick < 75) begin
			c.command = CMD_GET_COUNT;
		end else if (pick < 88) begin
			c.command = CMD_SET_EN;
			c.enable_value = ($urandom_range(0, 3) != 0);
		end else if (pick < 94) begin
			c.command = CMD_ADD;
		end else begin
			c.command = CMD_W'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
		end
		return c;
	endfunction

	task automatic send_command(input timer_cmd_t c);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid        <= 1'b1;
		cmd_bus.command      <= c.command;
		cmd_bus.channel      <= c.channel;
		cmd_bus.value        <= c.value;
		cmd_bus.enable_value <= c.enable_value;
		cmd_bus.has_handler  <= c.has_handler;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
		expected_rsps.push_back(apply_command(c));
		cmds_sent++;
		if (c.command == CMD_TICK)
			ticks_sent++;
	endtask

	task automatic send_random(input int n);
		repeat (n) send_command(random_command());
	endtask

	// Response side: random stalls, plus one long hold-off on request.
	initial begin : rsp_ready_driver
		int stall_left;
		stall_left = 0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = STALL_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_bus.ready <= 1'b0;
			end else if (no_idle) begin
				rsp_bus.ready <= 1'b1;
			end else begin
				rsp_bus.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	always @(posedge clk) begin : check_results
		timer_rsp_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (expected_rsps.size() == 0) begin
				errors++;
				$display("%0t: response with nothing expected: status %0d channel %0d",
					$time, rsp_bus.status, rsp_bus.new_channel);
			end else begin
				want = expected_rsps.pop_front();
				rsps_checked++;
				fires_seen += $countones(rsp_bus.fire_mask);
				if (rsp_bus.status !== want.status) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, rsp_bus.status);
				end
				if (rsp_bus.new_channel !== want.new_channel) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: new_channel expected %0d, got %0d",
							$time, want.new_channel, rsp_bus.new_channel);
				end
				if (rsp_bus.count_read !== want.count_read) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: count_read expected %h, got %h",
							$time, want.count_read, rsp_bus.count_read);
				end
				if (rsp_bus.fire_mask !== want.fire_mask) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: fire_mask expected %b, got %b",
							$time, want.fire_mask, rsp_bus.fire_mask);
				end
			end
		end
	end

	// Every command aimed at a channel must fail before anything is added.
	task automatic test_before_any_add();
		send_command(make_cmd(CMD_GET_COUNT, 3'd0, '0, 1'b1, 1'b1));
		send_command(make_cmd(CMD_SET_EN, 3'd3, '0, 1'b1, 1'b0));
		send_command(make_cmd(CMD_SET_COUNT, 3'd7, COUNT_ALL_ONES, 1'b0, 1'b0));
		send_command(make_cmd(CMD_TICK, 3'd0, '0, 1'b0, 1'b0));
	endtask

	// Firing on reaching the period, saturation with a zero period, and a
	// count written above the period firing on the following tick.
	task automatic test_add_and_tick();
		send_command(make_cmd(CMD_ADD, 3'd0, 64'd1, 1'b0, 1'b1));
		send_command(make_cmd(CMD_TICK, 3'd5, '0, 1'b1, 1'b0));
		send_command(make_cmd(CMD_ADD, 3'd0, 64'd3, 1'b0, 1'b1));
		send_command(make_cmd(CMD_ADD, 3'd0, 64'd0, 1'b0, 1'b1));
		send_command(make_cmd(CMD_ADD, 3'd0, 64'd5, 1'b0, 1'b0));
		send_command(make_cmd(CMD_SET_COUNT, 3'd2, COUNT_ALL_ONES, 1'b0, 1'b0));
		send_command(make_cmd(CMD_TICK, 3'd0, '0, 1'b0, 1'b0));
		send_command(make_cmd(CMD_GET_COUNT, 3'd2, '0, 1'b0, 1'b0));
		send_command(make_cmd(CMD_SET_COUNT, 3'd1, 64'd10, 1'b0, 1'b0));
		send_command(make_cmd(CMD_TICK, 3'd0, '0, 1'b0, 1'b0));
	endtask

	// A disabled channel ignores set count and reads back as zero.
	task automatic test_disabled_channel();
		send_command(make_cmd(CMD_SET_EN, 3'd0, '0, 1'b0, 1'b0));
		send_command(make_cmd(CMD_SET_COUNT, 3'd0, 64'd5, 1'b0, 1'b0));
		send_command(make_cmd(CMD_GET_COUNT, 3'd0, '0, 1'b0, 1'b0));
		send_command(make_cmd(CMD_SET_EN, 3'd0, '0, 1'b1, 1'b0));
	endtask

	// Fill the remaining channels, then an add that finds the bank full.
	task automatic test_fill_bank();
		send_command(make_cmd(CMD_ADD, 3'd7, COUNT_ALL_ONES, 1'b0, 1'b1));
		send_command(make_cmd(CMD_ADD, 3'd0, 64'd7, 1'b0, 1'b1));
		send_command(make_cmd(CMD_ADD, 3'd0, 64'd2, 1'b0, 1'b1));
		send_command(make_cmd(CMD_ADD, 3'd0, TOP_BIT_ONLY, 1'b0, 1'b1));
		send_command(make_cmd(CMD_ADD, 3'd0, 64'd1, 1'b1, 1'b1));
	endtask

	task automatic test_reserved_codes();
		send_command(make_cmd(CMD_RESERVED_LO, 3'd1, COUNT_ALL_ONES, 1'b1, 1'b1));
		send_command(make_cmd(CMD_RESERVED_HI, 3'd6, '0, 1'b0, 1'b0));
		send_command(make_cmd(CMD_TICK, 3'd0, '0, 1'b0, 1'b0));
	endtask

	task automatic test_random_mix();
		send_random(900);
	endtask

	// No idling on either side for a stretch of back-to-back transactions.
	task automatic test_streaming();
		no_idle = 1'b1;
		send_random(400);
		no_idle = 1'b0;
	endtask

	// The response side stalls for a long stretch while commands keep coming.
	task automatic test_backpressure();
		hold_off_req = 1'b1;
		send_random(350);
	endtask

	initial begin
		errors       = 0;
		cmds_sent    = 0;
		ticks_sent   = 0;
		rsps_checked = 0;
		fires_seen   = 0;
		no_idle      = 1'b0;
		hold_off_req = 1'b0;
		chans_added  = 0;
		for (int i = 0; i < CHANNELS_DEF; i++) begin
			chan_en[i]      = 1'b0;
			chan_count[i]   = '0;
			chan_period[i]  = '0;
			chan_handler[i] = 1'b0;
		end
		cmd_bus.valid        <= 1'b0;
		cmd_bus.command      <= CMD_TICK;
		cmd_bus.channel      <= '0;
		cmd_bus.value        <= '0;
		cmd_bus.enable_value <= 1'b0;
		cmd_bus.has_handler  <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		test_before_any_add();
		test_add_and_tick();
		test_disabled_channel();
		test_fill_bank();
		test_reserved_codes();
		test_random_mix();
		test_streaming();
		test_backpressure();

		cmd_bus.valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d responses to %0d commands (%0d ticks, %0d channel events).",
			rsps_checked, cmds_sent, ticks_sent, fires_seen);
		$display("Covered unadded and disabled channels, saturation, a full bank, %s",
			"reserved codes, back-to-back traffic and a long response stall.");
		if (errors == 0) begin
			$display("multi_channel_periodic_tick_timer_unit: match");
		end else begin
			$display("%0d field mismatches", errors);
			$display("multi_channel_periodic_tick_timer_unit: mismatch");
		end
		$finish;
	end

endmodule
